/* src/qrk4_pkg.sv */
`timescale 1ns / 1ps
package qrk4_pkg;

   localparam int COMPONENT_WIDTH_DEFAULT = 32;
   localparam logic [31:0] STEP_TIME_RESET = 32'd42949673;
   localparam int MUL_BITS = 33;
   localparam int PROD_BITS = 64 + MUL_BITS;
   localparam logic [1:0] STAGE_LAST = 2'd3;
   localparam logic [1:0] STAGE_HALF_LAST = 2'd1;
   localparam logic [1:0] COMP_LAST = 2'd3;
   localparam logic [1:0] TERM_LAST = 2'd2;

   typedef struct packed {
      logic signed [31:0] rate_start_x;
      logic signed [31:0] rate_start_y;
      logic signed [31:0] rate_start_z;
      logic signed [31:0] rate_mid_x;
      logic signed [31:0] rate_mid_y;
      logic signed [31:0] rate_mid_z;
      logic signed [31:0] rate_end_x;
      logic signed [31:0] rate_end_y;
      logic signed [31:0] rate_end_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_GO,
      ST_T_WAIT,
      ST_P_GO,
      ST_P_WAIT,
      ST_D_GO,
      ST_D_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SH_25,
      SH_32,
      SH_33
   } shift_type;

   typedef struct packed {
      logic [1:0] ridx;
      logic       neg;
      logic [1:0] cidx;
   } term_type;

   // rate axis, sign and quaternion component of each product term
   function automatic term_type term_sel(input logic [1:0] comp, input logic [1:0] term);
      term_type t;
      t = '{ridx: 2'd0, neg: 1'b0, cidx: 2'd0};
      case ({comp, term})
         4'b0000: t = '{ridx: 2'd0, neg: 1'b1, cidx: 2'd1};
         4'b0001: t = '{ridx: 2'd1, neg: 1'b1, cidx: 2'd2};
         4'b0010: t = '{ridx: 2'd2, neg: 1'b1, cidx: 2'd3};
         4'b0100: t = '{ridx: 2'd0, neg: 1'b0, cidx: 2'd0};
         4'b0101: t = '{ridx: 2'd2, neg: 1'b0, cidx: 2'd2};
         4'b0110: t = '{ridx: 2'd1, neg: 1'b1, cidx: 2'd3};
         4'b1000: t = '{ridx: 2'd1, neg: 1'b0, cidx: 2'd0};
         4'b1001: t = '{ridx: 2'd2, neg: 1'b1, cidx: 2'd1};
         4'b1010: t = '{ridx: 2'd0, neg: 1'b0, cidx: 2'd3};
         4'b1100: t = '{ridx: 2'd2, neg: 1'b0, cidx: 2'd0};
         4'b1101: t = '{ridx: 2'd1, neg: 1'b0, cidx: 2'd1};
         4'b1110: t = '{ridx: 2'd0, neg: 1'b1, cidx: 2'd2};
         default: t = '{ridx: 2'd0, neg: 1'b0, cidx: 2'd0};
      endcase
      return t;
   endfunction

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7fff_ffff) begin
         r = 32'sh7fff_ffff;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/qrk4_mul.sv */
`timescale 1ns / 1ps
module qrk4_mul import qrk4_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  op_a,
   input  logic signed [32:0]  op_b,
   input  shift_type           shift,
   output logic                done,
   output logic signed [63:0]  result
);

   logic [PROD_BITS-1:0] p_ff, p_in;
   logic [63:0]          ma_ff, ma_in;
   logic                 neg_ff, neg_in;
   shift_type            shift_ff, shift_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [64:0]          add;
   logic [PROD_BITS-1:0] shv;
   logic [PROD_BITS-1:0] mag;
   logic                 rem;
   logic [32:0]          mb;

   always_comb begin
      p_in     = p_ff;
      ma_in    = ma_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mb       = op_b[32] ? 33'(-op_b) : 33'(op_b);
      add      = {1'b0, p_ff[PROD_BITS-1:MUL_BITS]} + (p_ff[0] ? {1'b0, ma_ff} : 65'd0);
      if (start) begin
         ma_in    = op_a[63] ? 64'(-op_a) : 64'(op_a);
         neg_in   = op_a[63] ^ op_b[32];
         shift_in = shift;
         p_in     = {64'd0, mb};
         cnt_in   = 6'(MUL_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         p_in   = {add, p_ff[MUL_BITS-1:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      p_ff     <= p_in;
      ma_ff    <= ma_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
   end

   // floor to the target scale, saturate to 64 bits
   always_comb begin
      case (shift_ff)
         SH_25: begin
            shv = p_ff >> 25;
            rem = |p_ff[24:0];
         end
         SH_32: begin
            shv = p_ff >> 32;
            rem = |p_ff[31:0];
         end
         SH_33: begin
            shv = p_ff >> 33;
            rem = |p_ff[32:0];
         end
         default: begin
            shv = p_ff;
            rem = 1'b0;
         end
      endcase
      mag = shv + PROD_BITS'(rem);
      if (neg_ff) begin
         if (|mag[PROD_BITS-1:63]) begin
            result = {1'b1, 63'd0};
         end else begin
            result = -$signed(mag[63:0]);
         end
      end else begin
         if (|shv[PROD_BITS-1:63]) begin
            result = {1'b0, {63{1'b1}}};
         end else begin
            result = $signed(shv[63:0]);
         end
      end
   end

   assign done = done_ff;

endmodule

/* src/qrk4_div6.sv */
`timescale 1ns / 1ps
module qrk4_div6 (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  dividend,
   output logic                done,
   output logic signed [63:0]  quotient
);

   logic [63:0] mag_ff, mag_in;
   logic [63:0] quo_ff, quo_in;
   logic [2:0]  rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  r4;
   logic        ge;

   always_comb begin
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r4      = {rem_ff, mag_ff[63]};
      ge      = r4 >= 4'd6;
      if (start) begin
         neg_in  = dividend[63];
         // negative values round toward minus infinity
         mag_in  = dividend[63] ? 64'(-dividend) + 64'd5 : 64'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 3'(r4 - 4'd6) : r4[2:0];
         quo_in = {quo_ff[62:0], ge};
         mag_in = {mag_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

/* src/quaternion_rk4_attitude_update.sv */
`timescale 1ns / 1ps
// channel   ports                              beat
// req       req_valid req_stall req_data       nine body rates, one rk4 step
// rsp       rsp_valid rsp_stall rsp_data       updated quaternion
// csr       csr_valid csr_ready csr_data       step time, q0.32
//
// each beat runs 64 products through one bit-serial multiplier plus four serial
// divisions by six
// reset (synchronous) loads the identity quaternion and the default step time
// one beat in work at a time; a new req beat is taken while a rsp beat waits
// a stalled rsp holds the block at its final update until taken
module quaternion_rk4_attitude_update import qrk4_pkg::*; #(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff >>> (64 - COMPONENT_WIDTH);
   localparam logic signed [63:0] Q_MIN = ~Q_MAX;
   localparam logic signed [63:0] Q_ONE = (Q_MAX < 64'sd1073741824) ? Q_MAX
                                                                    : 64'sd1073741824;

   function automatic logic signed [63:0] sat_w(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX;
      end else if (v < Q_MIN) begin
         r = Q_MIN;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] ext(input logic signed [COMPONENT_WIDTH-1:0] v);
      return 64'(v);
   endfunction

   state_type                          state_ff, state_in;
   logic [1:0]                         stage_ff, stage_in;
   logic [1:0]                         comp_ff, comp_in;
   logic [1:0]                         term_ff, term_in;
   req_type                            req_ff, req_in;
   logic signed [COMPONENT_WIDTH-1:0]  q_ff [4];
   logic signed [COMPONENT_WIDTH-1:0]  q_in [4];
   logic signed [COMPONENT_WIDTH-1:0]  est_ff [4];
   logic signed [COMPONENT_WIDTH-1:0]  est_in [4];
   logic signed [COMPONENT_WIDTH-1:0]  est_nx_ff [4];
   logic signed [COMPONENT_WIDTH-1:0]  est_nx_in [4];
   logic signed [63:0]                 kacc_ff, kacc_in;
   logic signed [63:0]                 s_ff [4];
   logic signed [63:0]                 s_in [4];
   logic [31:0]                        step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rsp_type                            rsp_ff, rsp_in;

   logic               mul_start;
   logic signed [63:0] mul_a;
   logic signed [32:0] mul_b;
   shift_type          mul_shift;
   logic               mul_done;
   logic signed [63:0] mul_res;
   logic               div_start;
   logic               div_done;
   logic signed [63:0] div_res;

   term_type           ts;
   logic signed [31:0] rate;
   logic signed [32:0] rate_ext;
   logic signed [63:0] ksum;
   logic signed [63:0] upd;

   qrk4_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .shift  (mul_shift),
      .done   (mul_done),
      .result (mul_res)
   );

   qrk4_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_res),
      .done     (div_done),
      .quotient (div_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_T_GO;
         ST_T_GO:   state_in = ST_T_WAIT;
         ST_T_WAIT: begin
            if (mul_done) state_in = (term_ff == TERM_LAST) ? ST_P_GO : ST_T_GO;
         end
         ST_P_GO:   state_in = ST_P_WAIT;
         ST_P_WAIT: begin
            if (mul_done) state_in = (stage_ff == STAGE_LAST) ? ST_D_GO : ST_T_GO;
         end
         ST_D_GO:   state_in = ST_D_WAIT;
         ST_D_WAIT: begin
            if (div_done) state_in = (comp_ff == COMP_LAST) ? ST_OUT : ST_T_GO;
         end
         ST_OUT:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // operand selection
   always_comb begin
      ts = term_sel(comp_ff, term_ff);
      case ({stage_ff, ts.ridx})
         4'b0000: rate = req_ff.rate_start_x;
         4'b0001: rate = req_ff.rate_start_y;
         4'b0010: rate = req_ff.rate_start_z;
         4'b1100: rate = req_ff.rate_end_x;
         4'b1101: rate = req_ff.rate_end_y;
         4'b1110: rate = req_ff.rate_end_z;
         4'b0100, 4'b1000: rate = req_ff.rate_mid_x;
         4'b0101, 4'b1001: rate = req_ff.rate_mid_y;
         4'b0110, 4'b1010: rate = req_ff.rate_mid_z;
         default: rate = '0;
      endcase
      rate_ext  = 33'(rate);
      mul_start = (state_ff == ST_T_GO) || (state_ff == ST_P_GO);
      div_start = (state_ff == ST_D_GO);
      if (state_ff == ST_P_GO || state_ff == ST_P_WAIT) begin
         mul_a     = (stage_ff == STAGE_LAST) ? s_ff[comp_ff] : kacc_ff;
         mul_b     = {1'b0, step_ff};
         mul_shift = (stage_ff > STAGE_HALF_LAST) ? SH_32 : SH_33;
      end else begin
         mul_a     = ext(est_ff[ts.cidx]);
         mul_b     = ts.neg ? -rate_ext : rate_ext;
         mul_shift = SH_25;
      end
   end

   // datapath updates
   always_comb begin
      stage_in     = stage_ff;
      comp_in      = comp_ff;
      term_in      = term_ff;
      req_in       = req_ff;
      q_in         = q_ff;
      est_in       = est_ff;
      est_nx_in    = est_nx_ff;
      kacc_in      = kacc_ff;
      s_in         = s_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ksum         = (term_ff == 2'd0) ? mul_res : sadd(kacc_ff, mul_res);
      upd          = sat_w(sadd(ext(q_ff[comp_ff]), (stage_ff == STAGE_LAST) ? div_res
                                                                               : mul_res));
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (csr_valid) step_in = csr_data;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               est_in   = q_ff;
               stage_in = '0;
               comp_in  = '0;
               term_in  = '0;
            end
         end
         ST_T_WAIT: begin
            if (mul_done) begin
               kacc_in = ksum;
               if (term_ff == TERM_LAST) begin
                  term_in = '0;
                  case (stage_ff)
                     2'd0:    s_in[comp_ff] = ksum;
                     2'd3:    s_in[comp_ff] = sadd(s_ff[comp_ff], ksum);
                     default: s_in[comp_ff] = sadd(s_ff[comp_ff], sadd(ksum, ksum));
                  endcase
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
         end
         ST_P_WAIT: begin
            if (mul_done && stage_ff != STAGE_LAST) begin
               est_nx_in[comp_ff] = COMPONENT_WIDTH'(upd);
               comp_in            = comp_ff + 2'd1;
               if (comp_ff == COMP_LAST) begin
                  est_in     = est_nx_ff;
                  est_in[3]  = COMPONENT_WIDTH'(upd);
                  stage_in   = stage_ff + 2'd1;
               end
            end
         end
         ST_D_WAIT: begin
            if (div_done) begin
               q_in[comp_ff] = COMPONENT_WIDTH'(upd);
               comp_in       = comp_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_in.quat_w = sat32(ext(q_ff[0]));
               rsp_in.quat_x = sat32(ext(q_ff[1]));
               rsp_in.quat_y = sat32(ext(q_ff[2]));
               rsp_in.quat_z = sat32(ext(q_ff[3]));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= '0;
         comp_ff      <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_TIME_RESET;
         q_ff[0]      <= COMPONENT_WIDTH'(Q_ONE);
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         comp_ff      <= comp_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         q_ff         <= q_in;
      end
      req_ff    <= req_in;
      est_ff    <= est_in;
      est_nx_ff <= est_nx_in;
      kacc_ff   <= kacc_in;
      s_ff      <= s_in;
      rsp_ff    <= rsp_in;
   end

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_T_WAIT || state_ff == ST_P_WAIT))
      else $error("multiplier finished outside a wait state");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_D_WAIT && stage_ff == STAGE_LAST))
      else $error("divider finished outside the final update");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_T_GO && stage_ff == 2'd0
                                     && comp_ff == 2'd0 && term_ff == 2'd0))
      else $error("beat accepted without restarting the sequence");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not presented");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import qrk4_pkg::*;

   localparam int QW = 32;
   localparam longint CYCLE_LIMIT = 20_000_000;

   typedef logic signed [63:0] wide_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   bit          quiet = 1'b0;
   int          fails = 0;
   longint      cycles = 0;
   rsp_type     expected_quats[$];
   wide_type    att[4];
   logic [31:0] dt;

   quaternion_rk4_attitude_update #(.COMPONENT_WIDTH(QW)) uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);
   end

   function automatic wide_type sat_w(input logic signed [127:0] v, input int bits);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return wide_type'(hi);
      if (v < lo) return wide_type'(lo);
      return wide_type'(v);
   endfunction

   function automatic wide_type add_s(input wide_type a, input wide_type b);
      return sat_w(128'(a) + 128'(b), 64);
   endfunction

   function automatic wide_type mul_fl(input wide_type a, input wide_type b, input int s);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      return sat_w(p >>> s, 64);
   endfunction

   task automatic rate_deriv(input wide_type r[3], input wide_type q[4],
                             output wide_type k[4]);
      k[0] = add_s(add_s(mul_fl(-r[0], q[1], 25), mul_fl(-r[1], q[2], 25)),
                   mul_fl(-r[2], q[3], 25));
      k[1] = add_s(add_s(mul_fl(r[0], q[0], 25), mul_fl(r[2], q[2], 25)),
                   mul_fl(-r[1], q[3], 25));
      k[2] = add_s(add_s(mul_fl(r[1], q[0], 25), mul_fl(-r[2], q[1], 25)),
                   mul_fl(r[0], q[3], 25));
      k[3] = add_s(add_s(mul_fl(r[2], q[0], 25), mul_fl(r[1], q[1], 25)),
                   mul_fl(-r[0], q[2], 25));
   endtask

   task automatic estimate(input wide_type k[4], input int s, output wide_type e[4]);
      for (int i = 0; i < 4; i++) begin
         e[i] = sat_w(128'(add_s(att[i], mul_fl(wide_type'({32'd0, dt}), k[i], s))), QW);
      end
   endtask

   task automatic rk4_update(input req_type b, output rsp_type res);
      wide_type rs[3], rm[3], re[3];
      wide_type k1[4], k2[4], k3[4], k4[4], e[4];
      wide_type sum, t;
      logic signed [127:0] d;
      rs = '{wide_type'(b.rate_start_x), wide_type'(b.rate_start_y),
             wide_type'(b.rate_start_z)};
      rm = '{wide_type'(b.rate_mid_x), wide_type'(b.rate_mid_y), wide_type'(b.rate_mid_z)};
      re = '{wide_type'(b.rate_end_x), wide_type'(b.rate_end_y), wide_type'(b.rate_end_z)};
      rate_deriv(rs, att, k1);
      estimate(k1, 33, e);
      rate_deriv(rm, e, k2);
      estimate(k2, 33, e);
      rate_deriv(rm, e, k3);
      estimate(k3, 32, e);
      rate_deriv(re, e, k4);
      for (int i = 0; i < 4; i++) begin
         sum = add_s(add_s(add_s(k1[i], add_s(k2[i], k2[i])), add_s(k3[i], k3[i])), k4[i]);
         t = mul_fl(wide_type'({32'd0, dt}), sum, 32);
         if (t >= 0) d = 128'(t) / 6;
         else d = -((-128'(t) + 5) / 6);
         att[i] = sat_w(128'(att[i]) + d, QW);
      end
      res.quat_w = att[0][31:0];
      res.quat_x = att[1][31:0];
      res.quat_y = att[2][31:0];
      res.quat_z = att[3][31:0];
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quats.size() == 0) begin
            report("unexpected beat", rsp_data.quat_w, 32'd0);
         end else begin
            want = expected_quats.pop_front();
            if (rsp_data.quat_w !== want.quat_w) report("quat_w", rsp_data.quat_w, want.quat_w);
            if (rsp_data.quat_x !== want.quat_x) report("quat_x", rsp_data.quat_x, want.quat_x);
            if (rsp_data.quat_y !== want.quat_y) report("quat_y", rsp_data.quat_y, want.quat_y);
            if (rsp_data.quat_z !== want.quat_z) report("quat_z", rsp_data.quat_z, want.quat_z);
         end
      end
   end

   task automatic send_rates(input req_type b);
      rsp_type res;
      while (!quiet && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      rk4_update(b, res);
      expected_quats.push_back(res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_step(input logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      dt = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rnd_rate(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
         default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic req_type rnd_beat(input int mode);
      req_type b;
      b.rate_start_x = rnd_rate(mode);
      b.rate_start_y = rnd_rate(mode);
      b.rate_start_z = rnd_rate(mode);
      b.rate_mid_x = rnd_rate(mode);
      b.rate_mid_y = rnd_rate(mode);
      b.rate_mid_z = rnd_rate(mode);
      b.rate_end_x = rnd_rate(mode);
      b.rate_end_y = rnd_rate(mode);
      b.rate_end_z = rnd_rate(mode);
      return b;
   endfunction

   task automatic test_directed();
      req_type b;
      send_rates('0);
      for (int ax = 0; ax < 9; ax++) begin
         b = '0;
         b[ax*32 +: 32] = 32'sh0100_0000;
         send_rates(b);
      end
      send_rates({9{32'sh7fff_ffff}});
      send_rates({9{32'sh8000_0000}});
      set_step(32'd0);
      send_rates({9{32'sh0123_4567}});
      set_step(32'hffff_ffff);
      send_rates({9{32'sh8000_0000}});
      send_rates({9{32'sh7fff_ffff}});
      send_rates('0);
   endtask

   task automatic test_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 0) begin
            set_step(($urandom_range(3) == 0) ? $urandom : $urandom_range(32'd90_000_000));
         end
         quiet = (i >= 300 && i < 400);
         r = $urandom_range(99);
         send_rates(rnd_beat(r < 8 ? 0 : (r < 40 ? 1 : 2)));
      end
      quiet = 1'b0;
   endtask

   initial begin
      att = '{wide_type'(64'sd1 <<< 30), 0, 0, 0};
      dt = STEP_TIME_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_step(STEP_TIME_RESET);
      test_random(880);
      drain();
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* quaternion_rk4_attitude_update.f */
src/qrk4_pkg.sv
src/qrk4_mul.sv
src/qrk4_div6.sv
src/quaternion_rk4_attitude_update.sv
bench/tb_top.sv
